// ===== rtl/core/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the first-fit page bitmap allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Field widths of the transfer payloads and the register file.
  localparam int unsigned PageCountW = 11;
  localparam int unsigned StartPageW = 10;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  // Register indexes, taken from paddr[2].
  localparam logic RegValidPages  = 1'b0;
  localparam logic RegBaseAddress = 1'b1;

  // Register reset values.
  localparam logic [PageCountW-1:0] ValidPagesRst  = 11'd1024;
  localparam logic [AddrW-1:0]      BaseAddressRst = 32'h0010_0000;

  // Request kinds.
  typedef enum logic {
    ACT_INIT  = 1'b0,
    ACT_ALLOC = 1'b1
  } action_e;

  // Request payload.
  typedef struct packed {
    action_e               action;
    logic [PageCountW-1:0] page_count;
  } alloc_req_t;

  // Response payload.
  typedef struct packed {
    logic                  granted;
    logic [StartPageW-1:0] start_page;
    logic [AddrW-1:0]      address;
  } alloc_rsp_t;

  // Configuration handed from the register file to the engine.
  typedef struct packed {
    logic [PageCountW-1:0] valid_pages;
    logic [AddrW-1:0]      base_address;
  } cfg_t;

endpackage

// ===== rtl/core/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// Bitmap store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fbpa_ram import fbpa_pkg::*; #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [ByteW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem_q [DEPTH];
  logic [ByteW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, with the read data registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fbpa_cfg.sv =====
// ----------------------------------------------------------------------------
// fbpa_cfg
// APB register file holding the page count and the base address.
// ----------------------------------------------------------------------------
module fbpa_cfg import fbpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [PageCountW-1:0] valid_pages_q;
  logic [AddrW-1:0]      base_address_q;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_pages_q  <= ValidPagesRst;
      base_address_q <= BaseAddressRst;
    end else if (wr_en) begin
      case (paddr[2])
        RegValidPages:  valid_pages_q  <= pwdata[PageCountW-1:0];
        RegBaseAddress: base_address_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (paddr[2])
      RegValidPages:  prdata = CfgDataW'(valid_pages_q);
      RegBaseAddress: prdata = base_address_q;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.valid_pages  = valid_pages_q;
  assign cfg_o.base_address = base_address_q;

endmodule

// ===== rtl/core/fbpa_engine.sv =====
// ----------------------------------------------------------------------------
// fbpa_engine
// Sequencer around the bitmap store: clear, init, first-fit search, marking
// by read-modify-write, and the response register.
// ----------------------------------------------------------------------------
module fbpa_engine import fbpa_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = 128,
  parameter int unsigned PAGE_SHIFT   = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  alloc_req_t req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output alloc_rsp_t rsp_o
);

  localparam int unsigned AW   = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned PgW  = AW + 3;
  localparam int unsigned RunW = PgW + 1;
  localparam int unsigned CmpW = (RunW > PageCountW) ? RunW : PageCountW;
  localparam logic [AW-1:0] LastIdx = AW'(BITMAP_BYTES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SEARCH,
    ST_MARK,
    ST_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  rd_done_q, rd_done_d;
  logic                  proc_valid_q, proc_valid_d;
  logic [AW-1:0]         proc_idx_q, proc_idx_d;
  logic [PageCountW-1:0] want_q, want_d;
  logic [RunW-1:0]       run_q, run_d;
  logic [PgW-1:0]        rs_q, rs_d;
  logic [PgW-1:0]        start_q, start_d;
  logic [PgW-1:0]        end_q, end_d;
  logic                  found_q, found_d;
  logic                  out_valid_q, out_valid_d;
  alloc_rsp_t            rsp_q, rsp_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ByteW-1:0]      mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [ByteW-1:0]      mem_rdata;

  logic [RunW-1:0]       scan_run;
  logic [PgW-1:0]        scan_rs;
  logic                  scan_hit;
  logic [PgW-1:0]        scan_end;
  logic [ByteW-1:0]      init_byte;
  logic [ByteW-1:0]      mark_mask;
  logic [PgW+PAGE_SHIFT-1:0] page_off;
  logic [AW-1:0]         end_byte;

  fbpa_ram #(
    .DEPTH (BITMAP_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign end_byte = end_q[PgW-1:3];
  assign page_off = {start_q, {PAGE_SHIFT{1'b0}}};

  // Scan one bitmap byte, lowest page in the top bit, carrying the free run.
  always_comb begin
    scan_run = run_q;
    scan_rs  = rs_q;
    scan_hit = 1'b0;
    scan_end = end_q;
    for (int k = 0; k < ByteW; k++) begin
      if (!scan_hit) begin
        if (mem_rdata[ByteW-1-k]) begin
          scan_run = '0;
        end else begin
          if (scan_run == '0) begin
            scan_rs = {proc_idx_q, 3'(k)};
          end
          scan_run = scan_run + RunW'(1);
          if (CmpW'(scan_run) >= CmpW'(want_q)) begin
            scan_hit = 1'b1;
            scan_end = {proc_idx_q, 3'(k)};
          end
        end
      end
    end
  end

  // Init pattern: pages at or beyond the present count are used.
  // Mark pattern: pages inside the granted span are set.
  always_comb begin
    for (int k = 0; k < ByteW; k++) begin
      init_byte[ByteW-1-k] = CmpW'({idx_q, 3'(k)}) >= CmpW'(cfg_i.valid_pages);
      mark_mask[ByteW-1-k] = ({proc_idx_q, 3'(k)} >= start_q) &&
                             ({proc_idx_q, 3'(k)} <= end_q);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rd_done_d   = rd_done_q;
    want_d      = want_q;
    run_d       = run_q;
    rs_d        = rs_q;
    start_d     = start_q;
    end_d       = end_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;

    // The receiver takes the pending response.
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          idx_d     = '0;
          rd_done_d = 1'b0;
          run_d     = '0;
          rs_d      = '0;
          start_d   = '0;
          end_d     = '0;
          found_d   = 1'b0;
          want_d    = req_i.page_count;
          if (req_i.action == ACT_INIT) begin
            state_d = ST_INIT;
          end else if (req_i.page_count == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = init_byte;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_SEARCH: begin
        mem_re = !rd_done_q;
        if (!rd_done_q) begin
          if (idx_q == LastIdx) begin
            rd_done_d = 1'b1;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
        if (proc_valid_q) begin
          run_d = scan_run;
          rs_d  = scan_rs;
          if (scan_hit) begin
            // Drop the read in flight and restart at the first byte of the span.
            found_d   = 1'b1;
            start_d   = scan_rs;
            end_d     = scan_end;
            idx_d     = scan_rs[PgW-1:3];
            rd_done_d = 1'b0;
            mem_re    = 1'b0;
            state_d   = ST_MARK;
          end else if (proc_idx_q == LastIdx) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_MARK: begin
        // Read one byte ahead while the previous one is written back.
        mem_re = !rd_done_q;
        if (!rd_done_q) begin
          if (idx_q == end_byte) begin
            rd_done_d = 1'b1;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
        if (proc_valid_q) begin
          mem_we    = 1'b1;
          mem_waddr = proc_idx_q;
          mem_wdata = mem_rdata | mark_mask;
          if (proc_idx_q == end_byte) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_valid_d      = 1'b1;
          rsp_d.granted    = found_q;
          rsp_d.start_page = found_q ? StartPageW'(start_q) : '0;
          rsp_d.address    = found_q ? cfg_i.base_address + AddrW'(page_off) : '0;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign proc_valid_d = mem_re;
  assign proc_idx_d   = idx_q;
  assign req_ready_o  = (state_q == ST_IDLE);
  assign rsp_valid_o  = out_valid_q;
  assign rsp_o        = rsp_q;

  // State, sequencing registers and the response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      rd_done_q    <= 1'b0;
      proc_valid_q <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      proc_idx_q   <= '0;
      want_q       <= '0;
      run_q        <= '0;
      rs_q         <= '0;
      start_q      <= '0;
      end_q        <= '0;
      rsp_q        <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      rd_done_q    <= rd_done_d;
      proc_valid_q <= proc_valid_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
      proc_idx_q   <= proc_idx_d;
      want_q       <= want_d;
      run_q        <= run_d;
      rs_q         <= rs_d;
      start_q      <= start_d;
      end_q        <= end_d;
      rsp_q        <= rsp_d;
    end
  end

  // A write-back never targets the byte being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("bitmap write and read collide on one byte");

  // A first-fit hit closes a run exactly as long as the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && proc_valid_q && scan_hit) |->
    (CmpW'(scan_run) == CmpW'(want_q)))
    else $error("search hit with a run of the wrong length");

  // A granted span covers exactly the requested page count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && found_q) |->
    ((CmpW'(end_q) - CmpW'(start_q) + CmpW'(1)) == CmpW'(want_q)))
    else $error("granted span does not match the request");

  // Marking writes stay inside the bytes of the granted span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK && mem_we) |->
    (proc_idx_q >= start_q[PgW-1:3] && proc_idx_q <= end_byte))
    else $error("marking write outside the granted span");

endmodule

// ===== rtl/core/first_fit_page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_bitmap_allocator
// First-fit contiguous page allocator over a used-page bitmap.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (valid/ready) and each one produces one
// transfer on the rsp channel. An init request rewrites the bitmap so that
// every page at or beyond valid_pages is used; it answers with granted at 0.
// An allocate request searches for the lowest run of page_count free pages,
// marks it used and answers with the start page and its byte address.
// The bitmap lives in a one-port-read, one-port-write memory of BITMAP_BYTES
// bytes. Init rewrites every byte in turn and then answers. An allocation
// reads one byte per cycle and checks each byte in the cycle after its read;
// a failed search answers once the last byte is checked. A found run is then
// rewritten at one byte per cycle, each byte read one ahead of its write-back,
// and the answer follows the write of its last byte. A zero page count
// answers without a search. One request is in work at a time; the next is
// taken the cycle after the response loads. After reset a clearing pass
// writes zero to every byte, during which no request is taken; APB writes
// are taken as ever.
// The response sits in an output register, so a stalled receiver only holds
// the next response back; the following request is already accepted.
// ----------------------------------------------------------------------------
module first_fit_page_bitmap_allocator import fbpa_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = 128,
  parameter int unsigned PAGE_SHIFT   = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  alloc_req_t          req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output alloc_rsp_t          rsp_o
);

  cfg_t cfg;

  // Configuration registers.
  fbpa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Bitmap sequencer and response register.
  fbpa_engine #(
    .BITMAP_BYTES (BITMAP_BYTES),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== test/first_fit_page_bitmap_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_page_bitmap_allocator_tb
// Self-checking testbench for the first-fit page bitmap allocator.
// ----------------------------------------------------------------------------
// A class keeps its own copy of the page bitmap and the two registers. For
// every accepted request, it works out the response that the allocator
// should give. Each response transfer is checked field by field against the
// oldest expected one. A short directed part covers the edge cases: empty
// and oversized requests, a full bitmap, a zero page count, a page count
// beyond the bitmap and address wrap. Long random runs follow. They consist
// of init-then-allocate sequences with some noise; both channels stall at
// random in the first two runs and never in the last.
// ----------------------------------------------------------------------------
module first_fit_page_bitmap_allocator_tb;
  import fbpa_pkg::*;

  localparam int unsigned BitmapBytes = 128;
  localparam int unsigned PageShift   = 12;
  localparam int unsigned TotalPages  = BitmapBytes * ByteW;
  localparam int unsigned SettleCycles = 300;

  // Model of the allocator: bitmap, registers and the expected responses.
  class grant_predictor;
    logic [ByteW-1:0]      used_bytes [BitmapBytes];
    logic [PageCountW-1:0] valid_pages;
    logic [AddrW-1:0]      base_address;
    alloc_rsp_t            expected_grants [$];
    int unsigned           error_count;

    function new();
      foreach (used_bytes[i]) used_bytes[i] = '0;
      valid_pages  = ValidPagesRst;
      base_address = BaseAddressRst;
      error_count  = 0;
    endfunction

    function void write_register(logic index, logic [CfgDataW-1:0] value);
      if (index == RegValidPages) begin
        valid_pages = value[PageCountW-1:0];
      end else begin
        base_address = value[AddrW-1:0];
      end
    endfunction

    // The most significant bit of each byte holds the lowest page.
    function bit page_used(int unsigned page);
      return used_bytes[page / ByteW][ByteW - 1 - page % ByteW];
    endfunction

    function void mark_used(int unsigned page);
      used_bytes[page / ByteW][ByteW - 1 - page % ByteW] = 1'b1;
    endfunction

    // Applies one accepted request and queues the response it must produce.
    function void predict_grant(alloc_req_t req);
      alloc_rsp_t  rsp;
      int unsigned page;
      int unsigned run;
      int unsigned first;
      bit          found;
      rsp   = '0;
      run   = 0;
      first = 0;
      found = 1'b0;
      if (req.action == ACT_INIT) begin
        foreach (used_bytes[i]) used_bytes[i] = '0;
        for (page = valid_pages; page < TotalPages; page++) mark_used(page);
      end else if (req.page_count != '0) begin
        // First fit: the lowest start of a long enough free run.
        for (page = 0; page < TotalPages && !found; page++) begin
          if (page_used(page)) begin
            run = 0;
          end else begin
            run++;
            if (run >= req.page_count) begin
              first = page + 1 - req.page_count;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          for (page = first; page < first + req.page_count; page++) mark_used(page);
          rsp.granted    = 1'b1;
          rsp.start_page = first[StartPageW-1:0];
          rsp.address    = base_address + AddrW'(first << PageShift);
        end
      end
      expected_grants.push_back(rsp);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    task check_grant(alloc_rsp_t got);
      alloc_rsp_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected response %h", got));
      end else begin
        want = expected_grants.pop_front();
        if (got.granted !== want.granted) begin
          report_mismatch($sformatf("granted: expected %0b, got %0b",
                                    want.granted, got.granted));
        end
        if (got.start_page !== want.start_page) begin
          report_mismatch($sformatf("start_page: expected %0d, got %0d",
                                    want.start_page, got.start_page));
        end
        if (got.address !== want.address) begin
          report_mismatch($sformatf("address: expected %h, got %h",
                                    want.address, got.address));
        end
      end
    endtask

    task flag_leftovers();
      while (expected_grants.size() != 0) begin
        report_mismatch($sformatf("response never arrived: %h", expected_grants.pop_front()));
      end
    endtask

    function int unsigned outstanding();
      return expected_grants.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                req_valid_i;
  logic                req_ready_o;
  alloc_req_t          req_i;
  logic                rsp_valid_o;
  logic                rsp_ready_i;
  alloc_rsp_t          rsp_o;

  grant_predictor      ledger = new();
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;

  first_fit_page_bitmap_allocator #(
    .BITMAP_BYTES(BitmapBytes),
    .PAGE_SHIFT  (PageShift)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #20_000_000;
    $display("first_fit_page_bitmap_allocator test failed");
    $finish;
  end

  // Response side: check every transfer and stall at random.
  initial begin
    rsp_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_valid_o && rsp_ready_i) begin
        ledger.check_grant(rsp_o);
      end
      rsp_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request and returns at the edge of its transfer, valid held high.
  task automatic send_request(action_e action, logic [PageCountW-1:0] count);
    alloc_req_t req;
    req.action     = action;
    req.page_count = count;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= req;
    do @(posedge clk_i); while (!req_ready_o);
    ledger.predict_grant(req);
  endtask

  // Lowers valid and waits until every expected response has come back.
  task automatic drain();
    req_valid_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write: a setup phase, then an access phase.
  task automatic write_register(logic index, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.write_register(index, value);
  endtask

  task automatic reconfigure(logic [PageCountW-1:0] pages, logic [AddrW-1:0] base);
    drain();
    write_register(RegValidPages, CfgDataW'(pages));
    write_register(RegBaseAddress, base);
  endtask

  // Mostly small requests so that runs are reused, with some large or odd ones.
  function automatic logic [PageCountW-1:0] pick_page_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return PageCountW'($urandom_range(1, 16));
    if (roll < 80) return PageCountW'($urandom_range(17, 128));
    if (roll < 93) return PageCountW'($urandom_range(129, 1024));
    if (roll < 96) return '0;
    return PageCountW'($urandom_range(1025, 2047));
  endfunction

  // A random setting of both registers, the extremes included.
  task automatic random_config();
    logic [PageCountW-1:0] pages;
    logic [AddrW-1:0]      base;
    case ($urandom_range(9))
      0: pages = '0;
      1: pages = PageCountW'(TotalPages);
      2: pages = '1;
      3: pages = PageCountW'($urandom_range(1025, 2047));
      4: pages = PageCountW'($urandom_range(1, 16));
      default: pages = PageCountW'($urandom_range(0, 1024));
    endcase
    case ($urandom_range(7))
      0: base = '0;
      1: base = '1;
      2: base = 32'hFFFF_F000 - AddrW'($urandom_range(0, 64) << PageShift);
      default: base = $urandom;
    endcase
    reconfigure(pages, base);
  endtask

  // Init-then-allocate sequences with noise, a new setting every few sequences.
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned seq_len;
    sent = 0;
    while (sent < n_items) begin
      random_config();
      repeat ($urandom_range(2, 5)) begin
        // Now and then a sequence starts without an init.
        if ($urandom_range(9) != 0 && sent < n_items) begin
          send_request(ACT_INIT, PageCountW'($urandom));
          sent++;
        end
        seq_len = $urandom_range(3, 24);
        repeat (seq_len) begin
          if (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
              send_request($urandom_range(1) ? ACT_ALLOC : ACT_INIT,
                           PageCountW'($urandom_range(0, 2047)));
            end else begin
              send_request(ACT_ALLOC, pick_page_count());
            end
            sent++;
          end
        end
      end
    end
  endtask

  // Main sequence: reset, directed cases, then three random phases.
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_valid_i   = 1'b0;
    req_i         = '0;
    send_idle_pct = 26;
    recv_idle_pct = 73;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset state: every page free, so nothing is used before an init.
    send_request(ACT_ALLOC, 11'd1);
    send_request(ACT_ALLOC, 11'd0);
    send_request(ACT_ALLOC, 11'd1024);
    send_request(ACT_ALLOC, 11'd2047);
    send_request(ACT_INIT, 11'd2047);
    send_request(ACT_ALLOC, 11'd1024);
    send_request(ACT_ALLOC, 11'd1);
    send_request(ACT_INIT, 11'd0);
    send_request(ACT_ALLOC, 11'd3);
    send_request(ACT_ALLOC, 11'd5);
    send_request(ACT_ALLOC, 11'd1023);
    send_request(ACT_ALLOC, 11'd1016);
    send_request(ACT_ALLOC, 11'd1);

    // No pages present: all allocations fail.
    reconfigure('0, '1);
    send_request(ACT_INIT, 11'd5);
    send_request(ACT_ALLOC, 11'd1);

    // Count beyond the bitmap keeps every page free; the address wraps.
    reconfigure('1, 32'hFFFF_F000);
    send_request(ACT_INIT, 11'd0);
    send_request(ACT_ALLOC, 11'd1);
    send_request(ACT_ALLOC, 11'd1);
    send_request(ACT_ALLOC, 11'd1025);
    send_request(ACT_ALLOC, 11'd1022);

    // One page present.
    reconfigure(11'd1, '0);
    send_request(ACT_INIT, 11'd1024);
    send_request(ACT_ALLOC, 11'd1);
    send_request(ACT_ALLOC, 11'd1);

    run_random(317);
    drain();
    send_idle_pct = 73;
    recv_idle_pct = 26;
    run_random(317);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(316);

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    ledger.flag_leftovers();
    if (ledger.error_count == 0) begin
      $display("first_fit_page_bitmap_allocator test passed");
    end else begin
      $display("first_fit_page_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ram.sv
rtl/core/fbpa_cfg.sv
rtl/core/fbpa_engine.sv
rtl/core/first_fit_page_bitmap_allocator.sv
test/first_fit_page_bitmap_allocator_tb.sv
